[hdl/sia_pkg.sv]
// shared types and constants for the slot id allocator
`default_nettype none

package sia_pkg;

   localparam int SLOTS          = 64;
   localparam int VALUE_BITS     = 32;

   localparam int ROW_BITS       = 8;
   localparam int ROW_SEL_BITS   = 3;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 24;

   typedef logic [ROW_BITS-1:0]     row_type;
   typedef logic [ROW_SEL_BITS-1:0] row_sel_type;
   typedef logic [5:0]              idx_type;
   typedef logic [6:0]              cnt_type;
   typedef logic [1:0]              status_type;
   typedef logic [31:0]             payload_type;

   localparam logic       CMD_PUT      = 1'b0;
   localparam logic       CMD_REMOVE   = 1'b1;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUT_RD,
      ST_PUT_CHK,
      ST_RM_RD,
      ST_RM_CHK,
      ST_TRIM_RD,
      ST_TRIM_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      status_type status;
      idx_type    assigned_index;
      cnt_type    used_count;
      cnt_type    used_extent;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/sia_bitmap_ram.sv]
// occupancy bitmap memory, one row of slot bits per word, registered read
`default_nettype none

module sia_bitmap_ram #(
   parameter int ROWS = 8,
   parameter int RAW  = 3
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [RAW-1:0]       wr_addr,
   input  wire sia_pkg::row_type     wr_data,
   input  wire logic [RAW-1:0]       rd_addr,
   output sia_pkg::row_type          rd_data
);

   sia_pkg::row_type mem_ff [ROWS];
   sia_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/sia_value_ram.sv]
// stored slot values, one word per slot
`default_nettype none

module sia_value_ram #(
   parameter int SLOTS      = 64,
   parameter int VALUE_BITS = 32,
   parameter int IW         = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IW-1:0]         wr_addr,
   input  wire logic [VALUE_BITS-1:0] wr_data
);

   logic [VALUE_BITS-1:0] mem_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[hdl/sia_ctrl.sv]
// allocation sequencer: row scans of the bitmap, counters and result build
`default_nettype none

module sia_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_command,
   input  wire sia_pkg::idx_type      req_slot_index,
   input  wire sia_pkg::payload_type  req_payload,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output sia_pkg::rsp_type           res
);

   localparam int SLOTS      = sia_pkg::SLOTS;
   localparam int VALUE_BITS = sia_pkg::VALUE_BITS;
   localparam int RB   = sia_pkg::ROW_BITS;
   localparam int BW   = sia_pkg::ROW_SEL_BITS;
   localparam int ROWS = (SLOTS + RB - 1) / RB;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IW   = $clog2(SLOTS);
   localparam int CW   = $clog2(SLOTS + 1);

   sia_pkg::state_type  state_ff, state_in;
   logic [RAW-1:0]      row_ff, row_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       ext_ff, ext_in;
   sia_pkg::idx_type    idx_ff, idx_in;
   sia_pkg::payload_type val_ff, val_in;
   sia_pkg::rsp_type    res_ff, res_in;

   logic                bm_we;
   sia_pkg::row_type    bm_wdata;
   sia_pkg::row_type    bm_rdata;
   logic                val_we;

   sia_pkg::row_type    rd_or;
   logic                put_hit;
   sia_pkg::row_sel_type free_bit;
   sia_pkg::row_sel_type rm_bit;
   logic                rm_set;
   sia_pkg::row_type    rm_row_new;
   sia_pkg::row_type    trim_src;
   logic                trim_hit;
   sia_pkg::row_sel_type top_bit;
   logic                last_row;
   logic                row_zero;
   logic                trim_needed;
   logic                rm_oob;
   logic [CW-1:0]       put_ext;
   logic [CW-1:0]       trim_ext;

   function automatic sia_pkg::row_type pad_mask(input logic [RAW-1:0] row);
      sia_pkg::row_type m;
      m = '0;
      for (int b = 0; b < RB; b++) begin
         m[b] = (int'(row) * RB + b) >= SLOTS;
      end
      return m;
   endfunction

   function automatic sia_pkg::row_sel_type first_zero(input sia_pkg::row_type v);
      sia_pkg::row_sel_type r;
      r = '0;
      for (int i = RB - 1; i >= 0; i--) begin
         if (!v[i]) begin
            r = BW'(i);
         end
      end
      return r;
   endfunction

   function automatic sia_pkg::row_sel_type last_one(input sia_pkg::row_type v);
      sia_pkg::row_sel_type r;
      r = '0;
      for (int i = 0; i < RB; i++) begin
         if (v[i]) begin
            r = BW'(i);
         end
      end
      return r;
   endfunction

   sia_bitmap_ram #(
      .ROWS (ROWS),
      .RAW  (RAW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (row_ff),
      .wr_data (bm_wdata),
      .rd_addr (row_ff),
      .rd_data (bm_rdata)
   );

   sia_value_ram #(
      .SLOTS      (SLOTS),
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW)
   ) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (IW'({row_ff, free_bit})),
      .wr_data (VALUE_BITS'(val_ff))
   );

   assign rd_or       = bm_rdata | pad_mask(row_ff);
   assign put_hit     = ~&rd_or;
   assign free_bit    = first_zero(rd_or);
   assign rm_bit      = idx_ff[BW-1:0];
   assign rm_set      = bm_rdata[rm_bit];
   assign rm_row_new  = bm_rdata & ~(sia_pkg::row_type'(1) << rm_bit);
   assign trim_src    = (state_ff == sia_pkg::ST_RM_CHK) ? rm_row_new : bm_rdata;
   assign trim_hit    = |trim_src;
   assign top_bit     = last_one(trim_src);
   assign last_row    = row_ff == RAW'(ROWS - 1);
   assign row_zero    = row_ff == '0;
   assign trim_needed = 32'(ext_ff) == (32'(idx_ff) + 32'd1);
   assign rm_oob      = 32'(req_slot_index) >= 32'(SLOTS);
   assign put_ext     = CW'({row_ff, free_bit}) + CW'(1);
   assign trim_ext    = CW'({row_ff, top_bit}) + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sia_pkg::ST_CLEAR: begin
            if (last_row) begin
               state_in = sia_pkg::ST_IDLE;
            end
         end
         sia_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_command == sia_pkg::CMD_PUT) begin
                  state_in = sia_pkg::ST_PUT_RD;
               end else if (rm_oob) begin
                  state_in = sia_pkg::ST_DONE;
               end else begin
                  state_in = sia_pkg::ST_RM_RD;
               end
            end
         end
         sia_pkg::ST_PUT_RD: begin
            state_in = sia_pkg::ST_PUT_CHK;
         end
         sia_pkg::ST_PUT_CHK: begin
            if (put_hit || last_row) begin
               state_in = sia_pkg::ST_DONE;
            end else begin
               state_in = sia_pkg::ST_PUT_RD;
            end
         end
         sia_pkg::ST_RM_RD: begin
            state_in = sia_pkg::ST_RM_CHK;
         end
         sia_pkg::ST_RM_CHK: begin
            if (rm_set && trim_needed && !trim_hit && !row_zero) begin
               state_in = sia_pkg::ST_TRIM_RD;
            end else begin
               state_in = sia_pkg::ST_DONE;
            end
         end
         sia_pkg::ST_TRIM_RD: begin
            state_in = sia_pkg::ST_TRIM_CHK;
         end
         sia_pkg::ST_TRIM_CHK: begin
            if (trim_hit || row_zero) begin
               state_in = sia_pkg::ST_DONE;
            end else begin
               state_in = sia_pkg::ST_TRIM_RD;
            end
         end
         sia_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = sia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sia_pkg::ST_CLEAR;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      ext_in   = ext_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      res_in   = res_ff;
      bm_we    = 1'b0;
      bm_wdata = '0;
      val_we   = 1'b0;
      unique case (state_ff)
         sia_pkg::ST_CLEAR: begin
            bm_we  = 1'b1;
            row_in = row_ff + RAW'(1);
         end
         sia_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in = req_slot_index;
               val_in = req_payload;
               if (req_command == sia_pkg::CMD_PUT) begin
                  row_in = '0;
               end else begin
                  row_in = RAW'(req_slot_index >> BW);
               end
               res_in.status         = sia_pkg::STATUS_EMPTY;
               res_in.assigned_index = req_slot_index;
               res_in.used_count     = sia_pkg::cnt_type'(cnt_ff);
               res_in.used_extent    = sia_pkg::cnt_type'(ext_ff);
            end
         end
         sia_pkg::ST_PUT_CHK: begin
            if (put_hit) begin
               bm_we    = 1'b1;
               bm_wdata = bm_rdata | (sia_pkg::row_type'(1) << free_bit);
               val_we   = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               if (ext_ff < put_ext) begin
                  ext_in = put_ext;
               end
               res_in.status         = sia_pkg::STATUS_DONE;
               res_in.assigned_index = sia_pkg::idx_type'({row_ff, free_bit});
            end else if (last_row) begin
               res_in.status         = sia_pkg::STATUS_FULL;
               res_in.assigned_index = '0;
            end else begin
               row_in = row_ff + RAW'(1);
            end
            res_in.used_count  = sia_pkg::cnt_type'(cnt_in);
            res_in.used_extent = sia_pkg::cnt_type'(ext_in);
         end
         sia_pkg::ST_RM_CHK: begin
            if (rm_set) begin
               bm_we    = 1'b1;
               bm_wdata = rm_row_new;
               cnt_in   = cnt_ff - CW'(1);
               if (trim_needed) begin
                  if (trim_hit) begin
                     ext_in = trim_ext;
                  end else if (row_zero) begin
                     ext_in = '0;
                  end else begin
                     row_in = row_ff - RAW'(1);
                  end
               end
               res_in.status = sia_pkg::STATUS_DONE;
            end
            res_in.used_count  = sia_pkg::cnt_type'(cnt_in);
            res_in.used_extent = sia_pkg::cnt_type'(ext_in);
         end
         sia_pkg::ST_TRIM_CHK: begin
            if (trim_hit) begin
               ext_in = trim_ext;
            end else if (row_zero) begin
               ext_in = '0;
            end else begin
               row_in = row_ff - RAW'(1);
            end
            res_in.used_extent = sia_pkg::cnt_type'(ext_in);
         end
         sia_pkg::ST_PUT_RD,
         sia_pkg::ST_RM_RD,
         sia_pkg::ST_TRIM_RD,
         sia_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sia_pkg::ST_CLEAR;
         row_ff   <= '0;
         cnt_ff   <= '0;
         ext_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
         ext_ff   <= ext_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
      res_ff <= res_in;
   end

   assign req_ready = state_ff == sia_pkg::ST_IDLE;
   assign res_valid = state_ff == sia_pkg::ST_DONE;
   assign res       = res_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(SLOTS))
      else $error("occupied count beyond table size");

   a_count_in_extent: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ext_ff)
      else $error("occupied count above extent");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == sia_pkg::ST_CLEAR |-> !req_ready)
      else $error("transaction accepted during clearing pass");

   a_put_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sia_pkg::ST_PUT_CHK && put_hit) |=>
         cnt_ff == CW'($past(cnt_ff) + CW'(1)))
      else $error("successful put did not raise count");

endmodule

`default_nettype wire

[hdl/slot_id_allocator_top.sv]
// slot id allocator top level: stream ports and result register
`default_nettype none

// Lowest-free slot allocator over a table of SLOTS slots. A put transaction
// stores its payload in the lowest free slot and returns that slot; a remove
// transaction frees a named slot and trims the extent when the top slot goes.
// Occupancy lives in a bitmap memory of eight slots per row with a registered
// read, and each row visit has a read state and then a check and write-back
// state. A put visits rows upward from row 0 until it finds a free slot or
// has checked the last row; a remove visits the named row, then walks rows
// down while trimming the extent. After reset a clearing pass writes zero to
// every bitmap row in turn, and no transaction is taken until it ends. A
// finished result waits in an output register, so the next request is
// accepted while it is still pending.
module slot_id_allocator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // slot_index [5:0], payload [37:6], zero [39:38]
   input  wire logic [sia_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // command [0]
   input  wire logic [0:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // assigned_index [5:0], used_count [12:6], used_extent [19:13], zero [23:20]
   output logic [sia_pkg::RSP_TDATA_BITS-1:0]        rsp_tdata,
   // status [1:0]
   output logic [1:0]                                rsp_tuser
);

   logic             res_valid;
   logic             res_ready;
   sia_pkg::rsp_type res;
   logic             rsp_valid_ff, rsp_valid_in;
   sia_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sia_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_command    (req_tuser[0]),
      .req_slot_index (req_tdata[5:0]),
      .req_payload    (req_tdata[37:6]),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.used_extent, rsp_data_ff.used_count,
                        rsp_data_ff.assigned_index};

endmodule

`default_nettype wire
